### rtl/core/uf_pkg.sv
package uf_pkg;
  localparam int N_ELEMENTS = 1024;
  localparam int IDX_W = $clog2(N_ELEMENTS);
  localparam int RANK_W = 4;
  localparam int SIZE_W = 11;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic OP_FIND = 1'b0;
  localparam logic OP_UNITE = 1'b1;
endpackage

### rtl/core/uf_ram.sv
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/union_find_engine.sv
// Disjoint-set engine over 1024 elements with union by rank and full path
// compression. Parent, rank and size live in one single-port-read RAM each.
// After reset the block first sweeps all 1024 entries (one per cycle) to
// the initial state and accepts no item meanwhile. Every item is handled
// alone and returns one result. Cost per item is set by the parent RAM:
// the climb to the root follows one link per parent read, and rewriting
// the path visits each node through S_CWAIT, S_COMP and S_PWAIT. A unite
// climbs from a, then from b, then reads both roots' rank and size, and
// links them in S_LINK when two sets are merged. The block returns to
// idle after each result, and a result still held by out_stall delays
// the next one.
module union_find_engine
  import uf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [IDX_W-1:0]  elem_a,
  input  logic [IDX_W-1:0]  elem_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  root,
  output logic [SIZE_W-1:0] set_count,
  output logic              merged
);
  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_CLIMB  = 12'b000000000100,
    S_CWAIT  = 12'b000000001000,
    S_COMP   = 12'b000000010000,
    S_PWAIT  = 12'b000000100000,
    S_NEXT   = 12'b000001000000,
    S_RREQ   = 12'b000010000000,
    S_RWAIT  = 12'b000100000000,
    S_RBWAIT = 12'b001000000000,
    S_LINK   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state;
  logic [IDX_W:0]    clr_cnt;
  logic              op_r, second;
  logic [IDX_W-1:0]  b_r, start, cur, ra, top;
  logic [RANK_W-1:0] rank_a;

  // result held until the output side is free
  logic [IDX_W-1:0]  res_root;
  logic [SIZE_W-1:0] res_count;
  logic              res_merged;

  logic              p_we, r_we, s_we;
  logic [IDX_W-1:0]  p_wa, p_ra, r_wa, r_ra, s_wa, s_ra;
  logic [IDX_W-1:0]  p_wd, p_rd;
  logic [RANK_W-1:0] r_wd, r_rd;
  logic [SIZE_W-1:0] s_wd, s_rd, size_a;

  uf_ram #(.WIDTH(IDX_W), .DEPTH(N_ELEMENTS)) u_parent (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  uf_ram #(.WIDTH(RANK_W), .DEPTH(N_ELEMENTS)) u_rank (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  uf_ram #(.WIDTH(SIZE_W), .DEPTH(N_ELEMENTS)) u_size (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  assign in_stall = (state != S_IDLE);
  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  logic [IDX_W-1:0] hi, lo;
  logic             b_wins;
  // ra is the root of a (rank_a/size_a saved), top the root of b (r_rd/s_rd)
  assign b_wins = (rank_a < r_rd);
  assign hi = b_wins ? top : ra;
  assign lo = b_wins ? ra : top;

  // RAM port control
  always_comb begin
    p_we = 1'b0; p_wa = cur; p_wd = top; p_ra = cur;
    r_we = 1'b0; r_wa = hi; r_wd = r_rd; r_ra = ra;
    s_we = 1'b0; s_wa = hi; s_wd = s_rd; s_ra = ra;
    unique case (state)
      S_CLEAR: begin
        p_we = 1'b1; r_we = 1'b1; s_we = 1'b1;
        p_wa = clr_cnt[IDX_W-1:0]; p_wd = clr_cnt[IDX_W-1:0];
        r_wa = clr_cnt[IDX_W-1:0]; r_wd = '0;
        s_wa = clr_cnt[IDX_W-1:0]; s_wd = SIZE_W'(1);
      end
      S_IDLE: p_ra = elem_a;
      S_CLIMB: p_ra = p_rd;
      S_COMP: begin
        // rewrite current path node straight to the root
        p_we = (cur != top);
        p_ra = cur;
      end
      // start of the climb from b
      S_NEXT: p_ra = b_r;
      S_RREQ: begin
        r_ra = ra; s_ra = ra;
      end
      S_RWAIT: begin
        r_ra = top; s_ra = top;
      end
      // keep b's rank and size on the read ports for the link
      S_RBWAIT: begin
        r_ra = top; s_ra = top;
      end
      S_LINK: begin
        p_we = 1'b1; p_wa = lo; p_wd = hi;
        r_we = 1'b1; r_wa = hi;
        r_wd = (rank_a == r_rd && rank_a < RANK_MAX) ? rank_a + 1'b1
             : (b_wins ? r_rd : rank_a);
        s_we = 1'b1; s_wa = hi; s_wd = size_a + s_rd;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (IDX_W+1)'(N_ELEMENTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_xfer) begin
          op_r <= op; b_r <= elem_b; start <= elem_a; cur <= elem_a;
          second <= 1'b0; state <= S_CLIMB;
        end
        S_CLIMB: begin
          // p_rd = parent[cur]
          if (p_rd == cur) begin
            top <= cur; cur <= start; state <= S_CWAIT;
          end else begin
            cur <= p_rd;
          end
        end
        S_CWAIT: state <= S_COMP;
        S_COMP: begin
          // p_rd = old parent of cur (read issued last cycle)
          if (cur == top) state <= S_NEXT;
          else state <= S_PWAIT;
        end
        S_PWAIT: begin
          cur <= p_rd; state <= S_CWAIT;
        end
        S_NEXT: begin
          if (op_r == OP_UNITE && !second) begin
            ra <= top; second <= 1'b1; start <= b_r; cur <= b_r;
            state <= S_CLIMB;
          end else if (op_r == OP_UNITE) begin
            state <= S_RREQ;
          end else begin
            ra <= top; state <= S_RREQ;
          end
        end
        S_RREQ: state <= S_RWAIT;
        S_RWAIT: begin
          rank_a <= r_rd; size_a <= s_rd;
          state <= S_RBWAIT;
        end
        S_RBWAIT: begin
          if (op_r == OP_FIND || ra == top) begin
            res_root <= ra; res_count <= size_a; res_merged <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          res_root <= hi; res_count <= size_a + s_rd; res_merged <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (!out_valid) begin
          root <= res_root; set_count <= res_count; merged <= res_merged;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb.sv
module tb;
  import uf_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [IDX_W-1:0]  elem_a;
  logic [IDX_W-1:0]  elem_b;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  root;
  logic [SIZE_W-1:0] set_count;
  logic              merged;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
  } uf_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  root;
    logic [SIZE_W-1:0] count;
    logic              merged;
  } uf_rsp_t;

  uf_req_t   req_q[$];
  logic      drain_q[$];
  uf_rsp_t   rsp_q[$];

  // Shadow disjoint-set state
  logic [IDX_W-1:0]  par_m[N_ELEMENTS];
  logic [RANK_W-1:0] rank_m[N_ELEMENTS];
  logic [SIZE_W-1:0] size_m[N_ELEMENTS];

  int  errors;
  int  cycle_cnt;
  bit  stim_done;

  union_find_engine u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .elem_a(elem_a), .elem_b(elem_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .root(root), .set_count(set_count), .merged(merged)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [IDX_W-1:0] find_root(logic [IDX_W-1:0] e);
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] walk;
    logic [IDX_W-1:0] up;
    top = e;
    while (par_m[top] != top) top = par_m[top];
    walk = e;
    while (walk != top) begin
      up = par_m[walk];
      par_m[walk] = top;
      walk = up;
    end
    return top;
  endfunction

  function automatic uf_rsp_t apply_op(uf_req_t r);
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    uf_rsp_t          res;
    res.merged = 1'b0;
    ra = find_root(r.a);
    if (r.op == OP_UNITE) begin
      rb = find_root(r.b);
      if (ra != rb) begin
        hi = ra;
        lo = rb;
        if (rank_m[ra] < rank_m[rb]) begin
          hi = rb;
          lo = ra;
        end
        par_m[lo] = hi;
        size_m[hi] = size_m[hi] + size_m[lo];
        if (rank_m[hi] == rank_m[lo] && rank_m[hi] < RANK_MAX)
          rank_m[hi] = rank_m[hi] + 1'b1;
        ra = hi;
        res.merged = 1'b1;
      end
    end
    res.root = ra;
    res.count = size_m[ra];
    return res;
  endfunction

  task automatic push_req(logic o, int a, int b);
    uf_req_t r;
    r.op = o;
    r.a = a[IDX_W-1:0];
    r.b = b[IDX_W-1:0];
    req_q.push_back(r);
    drain_q.push_back(1'b0);
  endtask

  task automatic push_drain();
    uf_req_t r;
    r = '0;
    req_q.push_back(r);
    drain_q.push_back(1'b1);
  endtask

  // Stimulus
  initial begin
    int base;
    int k;
    int w;
    int j;
    for (int i = 0; i < N_ELEMENTS; i++) begin
      par_m[i] = IDX_W'(i);
      rank_m[i] = '0;
      size_m[i] = SIZE_W'(1);
    end
    stim_done = 0;

    // Directed: extremes, both ops, self-unite, same-set unite, rank ties
    push_req(OP_FIND, 0, 1023);
    push_req(OP_FIND, 1023, 0);
    push_req(OP_UNITE, 0, 1023);
    push_req(OP_UNITE, 1023, 0);
    push_req(OP_UNITE, 5, 5);
    push_req(OP_UNITE, 1, 2);
    push_req(OP_UNITE, 3, 4);
    push_req(OP_UNITE, 1, 3);
    push_req(OP_UNITE, 6, 1);
    push_req(OP_FIND, 4, 0);
    push_req(OP_FIND, 4, 0);
    push_req(OP_UNITE, 4, 0);
    push_req(OP_UNITE, 2, 1023);
    push_req(OP_FIND, 682, 341);
    push_req(OP_FIND, 341, 682);
    push_drain();

    // Random: blocks mixing unites and finds over a small pool build deep trees
    for (int blk = 0; blk < 12; blk++) begin
      base = $urandom_range(0, N_ELEMENTS - 64);
      w = (blk % 3 == 0) ? 63 : $urandom_range(7, 40);
      for (j = 0; j < 100; j++) begin
        k = $urandom_range(0, 99);
        if (k < 45)
          push_req(OP_UNITE, base + $urandom_range(0, w), base + $urandom_range(0, w));
        else if (k < 85)
          push_req(OP_FIND, base + $urandom_range(0, w), $urandom_range(0, 1023));
        else if (k < 95)
          push_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                   $urandom_range(0, 1023));
        else
          push_req(OP_UNITE, $urandom_range(0, 1023), base + $urandom_range(0, w));
      end
      if (blk == 6) push_drain();
    end
    stim_done = 1;
  end

  // Driver
  int       in_gap;
  uf_req_t  cur_req;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      op <= OP_FIND;
      elem_a <= '0;
      elem_b <= '0;
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      rsp_q.push_back(apply_op(cur_req));
      in_valid <= 1'b0;
      in_gap <= $urandom_range(0, 5);
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (req_q.size() > 0) begin
        if (drain_q[0]) begin
          if (rsp_q.size() == 0) begin
            void'(req_q.pop_front());
            void'(drain_q.pop_front());
          end
        end else begin
          cur_req = req_q.pop_front();
          void'(drain_q.pop_front());
          op <= cur_req.op;
          elem_a <= cur_req.a;
          elem_b <= cur_req.b;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor and output stall generation
  int out_gap;
  always @(posedge clk) begin
    uf_rsp_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      errors <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("ERROR: unexpected result root=%0d", root);
        end else begin
          exp_r = rsp_q.pop_front();
          if (root !== exp_r.root || set_count !== exp_r.count ||
              merged !== exp_r.merged) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("ERROR: root %0d/%0d count %0d/%0d merged %0b/%0b (exp/act)",
                       exp_r.root, root, exp_r.count, set_count, exp_r.merged, merged);
          end
        end
        out_gap <= $urandom_range(0, 5);
        out_stall <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= (out_gap > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Reset, end of run and timeout
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // sample between edges so queue and handshake updates have settled
    do @(negedge clk);
    while (!(stim_done && req_q.size() == 0 && !in_valid && rsp_q.size() == 0));
    repeat (50) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > 400000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

### files.f
rtl/core/uf_pkg.sv
rtl/core/uf_ram.sv
rtl/core/union_find_engine.sv
tb/tb.sv
